// ----- rtl/itpb_pkg.sv -----
`default_nettype none
package itpb_pkg;

	localparam int FIFO_DEPTH_DEF = 16;
	localparam int TARGET_W = 16;
	localparam int COUNT_W = 17;
	localparam int BATCH_W = 32;
	localparam logic [TARGET_W-1:0] TARGET_RESET = 16'd2;
	localparam logic [COUNT_W-1:0] SAMPLES_PER_PAIR = 17'd2;

	localparam logic KIND_ACCEL = 1'b0;
	localparam logic KIND_GYRO = 1'b1;

	typedef struct packed {
		logic        kind;
		logic [63:0] word_low;
		logic [63:0] word_high;
		logic [63:0] timestamp;
	} in_item_t;

	typedef struct packed {
		logic [63:0]        accel_low;
		logic [63:0]        accel_high;
		logic [63:0]        gyro_low;
		logic [63:0]        gyro_high;
		logic [63:0]        pair_time;
		logic [BATCH_W-1:0] batch_number;
		logic               last_in_batch;
	} pair_t;

	typedef struct packed {
		logic [63:0] word_high;
		logic [63:0] word_low;
		logic [63:0] timestamp;
	} entry_t;

	// handshake between the request queue and the scan engine
	typedef struct packed {
		logic     valid;
		in_item_t item;
	} queue_head_t;

endpackage
`default_nettype wire

// ----- rtl/imu_timestamp_pair_batcher_core.sv -----
`default_nettype none
// accel/gyro timestamp pairing with batch marking
// requests: start with item (kind, two sample words, timestamp), taken when busy is low.
// requests go into a two-deep queue, so busy rises only when two are still waiting.
// the scan engine pulls one request at a time and walks the other sensor's ring from
// its oldest entry: older entries are dropped, an equal one forms a pair, a newer one
// or an empty ring queues the request in its own ring (dropped if that ring is full).
// each ring holds FIFO_DEPTH-1 entries in a registered-read ram, one read per step.
// a request passes through the check state and then the compare state; each entry
// discarded costs one ram read and one compare and returns the engine to check, and
// a newer entry or an empty ring leads to push before the engine goes back to idle.
// a pair appears on result with result_strobe high for exactly one cycle; the
// receiver cannot hold it off, and the next request is popped only in idle.
// cfg_we writes batch_target from cfg_wdata; write it only while idle.
// reset empties both rings and the queue, clears sample and batch counts and sets
// batch_target to 2; ring contents are not cleared.
module imu_timestamp_pair_batcher_core
	import itpb_pkg::*;
#(
	parameter int FIFO_DEPTH = FIFO_DEPTH_DEF
) (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                start,
	output logic                     busy,
	input  wire in_item_t            item,
	input  wire logic                cfg_we,
	input  wire logic [TARGET_W-1:0] cfg_wdata,
	output pair_t                    result,
	output logic                     result_strobe
);

	queue_head_t q_head;
	logic        q_pop;

	itpb_front u_front (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.busy   (busy),
		.item   (item),
		.head   (q_head),
		.pop    (q_pop)
	);

	itpb_back #(.FIFO_DEPTH(FIFO_DEPTH)) u_back (
		.clk           (clk),
		.arst_n        (arst_n),
		.head          (q_head),
		.pop           (q_pop),
		.cfg_we        (cfg_we),
		.cfg_wdata     (cfg_wdata),
		.result        (result),
		.result_strobe (result_strobe)
	);

endmodule
`default_nettype wire

// ----- rtl/itpb_ram.sv -----
`default_nettype none
module itpb_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule
`default_nettype wire

// ----- rtl/itpb_front.sv -----
`default_nettype none
module itpb_front
	import itpb_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        start,
	output logic             busy,
	input  wire in_item_t    item,
	output queue_head_t      head,
	input  wire logic        pop
);

	in_item_t   slot_q [2];
	logic       wr_ptr_q;
	logic       rd_ptr_q;
	logic [1:0] count_q;
	logic       push;
	logic       do_pop;

	assign busy   = (count_q == 2'd2);
	assign push   = start && !busy;
	assign do_pop = pop && (count_q != 2'd0);

	assign head.valid = (count_q != 2'd0);
	assign head.item  = slot_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_ptr_q] <= item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= !wr_ptr_q;
			end
			if (do_pop) begin
				rd_ptr_q <= !rd_ptr_q;
			end
			case ({push, do_pop})
				2'b10:   count_q <= count_q + 2'd1;
				2'b01:   count_q <= count_q - 2'd1;
				default: count_q <= count_q;
			endcase
		end
	end

endmodule
`default_nettype wire

// ----- rtl/itpb_back.sv -----
`default_nettype none
module itpb_back
	import itpb_pkg::*;
#(
	parameter int FIFO_DEPTH = FIFO_DEPTH_DEF
) (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire queue_head_t         head,
	output logic                     pop,
	input  wire logic                cfg_we,
	input  wire logic [TARGET_W-1:0] cfg_wdata,
	output pair_t                    result,
	output logic                     result_strobe
);

	localparam int PTR_W = $clog2(FIFO_DEPTH);
	localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(FIFO_DEPTH - 1);
	localparam int ENTRY_W = $bits(entry_t);

	typedef enum logic [3:0] {
		ST_IDLE  = 4'b0001,
		ST_CHECK = 4'b0010,
		ST_CMP   = 4'b0100,
		ST_PUSH  = 4'b1000
	} state_t;

	state_t               state_q;
	in_item_t             cur_q;
	logic [PTR_W-1:0]     a_head_q, a_tail_q, g_head_q, g_tail_q;
	logic [COUNT_W-1:0]   samples_q;
	logic [BATCH_W-1:0]   batch_q;
	logic [TARGET_W-1:0]  target_q;

	logic [ENTRY_W-1:0]   a_rdata, g_rdata, wdata;
	entry_t               other_entry;
	logic [PTR_W-1:0]     oth_head, oth_tail, own_head, own_tail;
	logic [PTR_W-1:0]     oth_tail_nx, own_head_nx;
	logic                 own_full;
	logic                 a_we, g_we;
	logic                 ts_lt, ts_eq;
	logic [COUNT_W-1:0]   cnt_nx;
	logic                 last;

	function automatic logic [PTR_W-1:0] ring_next(input logic [PTR_W-1:0] p);
		return (p == PTR_LAST) ? '0 : p + PTR_W'(1);
	endfunction

	// a gyro sample scans the accel ring and vice versa
	assign oth_head = (cur_q.kind == KIND_GYRO) ? a_head_q : g_head_q;
	assign oth_tail = (cur_q.kind == KIND_GYRO) ? a_tail_q : g_tail_q;
	assign own_head = (cur_q.kind == KIND_GYRO) ? g_head_q : a_head_q;
	assign own_tail = (cur_q.kind == KIND_GYRO) ? g_tail_q : a_tail_q;
	assign oth_tail_nx = ring_next(oth_tail);
	assign own_head_nx = ring_next(own_head);
	assign own_full    = (own_head_nx == own_tail);

	assign other_entry = entry_t'((cur_q.kind == KIND_GYRO) ? a_rdata : g_rdata);
	assign ts_lt = other_entry.timestamp < cur_q.timestamp;
	assign ts_eq = other_entry.timestamp == cur_q.timestamp;

	assign cnt_nx = samples_q + SAMPLES_PER_PAIR;
	assign last   = cnt_nx >= {1'b0, target_q};

	assign pop = (state_q == ST_IDLE) && head.valid;

	assign wdata = ENTRY_W'({cur_q.word_high, cur_q.word_low, cur_q.timestamp});
	assign a_we  = (state_q == ST_PUSH) && !own_full && (cur_q.kind == KIND_ACCEL);
	assign g_we  = (state_q == ST_PUSH) && !own_full && (cur_q.kind == KIND_GYRO);

	// read ports always follow the tails, data read in ST_CHECK is registered and lands in ST_CMP
	itpb_ram #(.WIDTH(ENTRY_W), .DEPTH(FIFO_DEPTH)) u_accel_ram (
		.clk   (clk),
		.we    (a_we),
		.waddr (a_head_q),
		.wdata (wdata),
		.raddr (a_tail_q),
		.rdata (a_rdata)
	);

	itpb_ram #(.WIDTH(ENTRY_W), .DEPTH(FIFO_DEPTH)) u_gyro_ram (
		.clk   (clk),
		.we    (g_we),
		.waddr (g_head_q),
		.wdata (wdata),
		.raddr (g_tail_q),
		.rdata (g_rdata)
	);

	always_ff @(posedge clk) begin
		if (pop) begin
			cur_q <= head.item;
		end
		if (state_q == ST_CMP && ts_eq) begin
			if (cur_q.kind == KIND_ACCEL) begin
				result.accel_low  <= cur_q.word_low;
				result.accel_high <= cur_q.word_high;
				result.gyro_low   <= other_entry.word_low;
				result.gyro_high  <= other_entry.word_high;
			end else begin
				result.accel_low  <= other_entry.word_low;
				result.accel_high <= other_entry.word_high;
				result.gyro_low   <= cur_q.word_low;
				result.gyro_high  <= cur_q.word_high;
			end
			result.pair_time     <= cur_q.timestamp;
			result.batch_number  <= batch_q;
			result.last_in_batch <= last;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= ST_IDLE;
			a_head_q      <= '0;
			a_tail_q      <= '0;
			g_head_q      <= '0;
			g_tail_q      <= '0;
			samples_q     <= '0;
			batch_q       <= '0;
			target_q      <= TARGET_RESET;
			result_strobe <= 1'b0;
		end else begin
			result_strobe <= 1'b0;
			if (cfg_we) begin
				target_q <= cfg_wdata;
			end
			case (state_q)
				ST_IDLE: begin
					if (head.valid) begin
						state_q <= ST_CHECK;
					end
				end
				ST_CHECK: begin
					state_q <= (oth_tail == oth_head) ? ST_PUSH : ST_CMP;
				end
				ST_CMP: begin
					if (ts_lt || ts_eq) begin
						if (cur_q.kind == KIND_GYRO) begin
							a_tail_q <= oth_tail_nx;
						end else begin
							g_tail_q <= oth_tail_nx;
						end
					end
					if (ts_eq) begin
						result_strobe <= 1'b1;
						if (last) begin
							samples_q <= '0;
							batch_q   <= batch_q + BATCH_W'(1);
						end else begin
							samples_q <= cnt_nx;
						end
						state_q <= ST_IDLE;
					end else if (ts_lt) begin
						state_q <= ST_CHECK;
					end else begin
						state_q <= ST_PUSH;
					end
				end
				ST_PUSH: begin
					if (!own_full) begin
						if (cur_q.kind == KIND_GYRO) begin
							g_head_q <= own_head_nx;
						end else begin
							a_head_q <= own_head_nx;
						end
					end
					state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

endmodule
`default_nettype wire
